>>> hdl/bfss_pkg.sv
package bfss_pkg;

    localparam int INO_W = 15;
    localparam int BLK_W = 16;
    localparam int POS_W = 17;
    localparam int WORD_W = 32;
    localparam int LEN_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CACHE_AW = 12;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_INODE = 2'd1;
    localparam logic [1:0] FUNC_BLOCK = 2'd2;
    localparam logic [1:0] FUNC_RUN   = 2'd3;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_WRITTEN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IPG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ICNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BCNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FDB   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_CAND,
        S_PROBE,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [INO_W-1:0] dividend;
        logic [INO_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [INO_W-1:0] rem;
    } t_rem_rsp;

endpackage

>>> hdl/bfss_req_if.sv
interface bfss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        bitmap_select;
    logic [10:0] word_index;
    logic [31:0] word_data;
    logic [14:0] dir_inode;
    logic [15:0] start_block;
    logic [15:0] finish_block;
    logic [7:0]  run_length;

    modport source (
        output valid, func, bitmap_select, word_index, word_data, dir_inode,
               start_block, finish_block, run_length,
        input  ready
    );
    modport sink (
        input  valid, func, bitmap_select, word_index, word_data, dir_inode,
               start_block, finish_block, run_length,
        output ready
    );
endinterface

>>> hdl/bfss_rsp_if.sv
interface bfss_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] found_number;

    modport source (output valid, status, found_number, input ready);
    modport sink (input valid, status, found_number, output ready);
endinterface

>>> hdl/bitmap_free_slot_search.sv
// A word write is stored when it is accepted, and its status word is valid in the next cycle.
// An inode search first waits for the group remainder unit to finish.
// Each candidate then passes through the candidate state and probes one bit at a time;
// a bitmap word that misses the one-word cache is fetched through the wait state.
// Reset is synchronous and active low; it restores the default configuration
// and idles the sequencer. Bitmap contents are undefined until written.
module bitmap_free_slot_search #(
    parameter int BLOCK_BITS = 65536,
    parameter int INODE_BITS = 16384,
    parameter int MAX_RUN    = 255
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bfss_req_if.sink                          i_req,
    bfss_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [bfss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bfss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int BLOCK_WORDS = BLOCK_BITS / 32;
    localparam int INODE_WORDS = INODE_BITS / 32;
    localparam int BAW = $clog2(BLOCK_WORDS);
    localparam int IAW = $clog2(INODE_WORDS);
    localparam int PW  = bfss_pkg::POS_W;

    bfss_pkg::t_state r_state, n_state;

    logic [14:0] r_ipg, r_icnt, r_fino;
    logic [16:0] r_bcnt;
    logic        r_fdb;

    logic [1:0]          r_func;
    logic [14:0]         r_dir;
    logic [15:0]         r_sblk, r_fblk;
    logic [7:0]          r_rlen;

    logic [PW-1:0] r_lo, n_lo, r_hi, n_hi, r_n, n_n, r_k, n_k;
    logic [PW-1:0] r_cand, n_cand, r_pos, n_pos, r_skip, n_skip;
    logic          r_skip_v, n_skip_v;
    logic [15:0]   r_fin, n_fin;
    logic          r_use_fin, n_use_fin;
    logic [7:0]    r_len, n_len;
    logic          r_isel, n_isel;

    logic                         r_cw_v, n_cw_v;
    logic [bfss_pkg::CACHE_AW-1:0] r_cw_addr, n_cw_addr;
    logic [31:0]                  r_cw_data, n_cw_data;

    logic        r_out_v, n_out_v;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_found, n_found;

    logic w_acc;
    bfss_pkg::t_rem_req w_rem_req;
    bfss_pkg::t_rem_rsp w_rem_rsp;
    logic [31:0] w_brd, w_ird;

    assign i_req.ready = (r_state == bfss_pkg::S_IDLE) && !r_out_v;
    assign w_acc       = i_req.valid && i_req.ready;

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.status       = r_status;
    assign o_rsp.found_number = r_found;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipg  <= 15'd2048;
            r_icnt <= 15'd16384;
            r_fino <= 15'd11;
            r_bcnt <= 17'd65536;
            r_fdb  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfss_pkg::CFG_IPG:  r_ipg  <= i_cfg_data[14:0];
                bfss_pkg::CFG_ICNT: r_icnt <= i_cfg_data[14:0];
                bfss_pkg::CFG_FINO: r_fino <= i_cfg_data[14:0];
                bfss_pkg::CFG_BCNT: r_bcnt <= i_cfg_data;
                bfss_pkg::CFG_FDB:  r_fdb  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Bitmap stores.
    logic w_bwe, w_iwe;
    logic [PW-1:0] w_bitidx;
    logic [bfss_pkg::CACHE_AW-1:0] w_waddr;

    assign w_bwe = w_acc && (i_req.func == bfss_pkg::FUNC_WRITE) && !i_req.bitmap_select
                   && (32'(i_req.word_index) < BLOCK_WORDS);
    assign w_iwe = w_acc && (i_req.func == bfss_pkg::FUNC_WRITE) && i_req.bitmap_select
                   && (32'(i_req.word_index) < INODE_WORDS);

    bfss_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_bram (
        .i_clk   (i_clk),
        .i_we    (w_bwe),
        .i_waddr (BAW'(i_req.word_index)),
        .i_wdata (i_req.word_data),
        .i_raddr (BAW'(w_waddr)),
        .o_rdata (w_brd)
    );

    bfss_ram #(.WIDTH(32), .DEPTH(INODE_WORDS)) u_iram (
        .i_clk   (i_clk),
        .i_we    (w_iwe),
        .i_waddr (IAW'(i_req.word_index)),
        .i_wdata (i_req.word_data),
        .i_raddr (IAW'(w_waddr)),
        .o_rdata (w_ird)
    );

    // Group remainder for the inode start point.
    assign w_rem_req.start    = w_acc && (i_req.func == bfss_pkg::FUNC_INODE);
    assign w_rem_req.dividend = i_req.dir_inode - 15'd1;
    assign w_rem_req.divisor  = r_ipg;

    bfss_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_rsp   (w_rem_rsp)
    );

    // Search set-up.
    logic [PW-1:0] w_ilo, w_ihi, w_is, w_bh, w_blo, w_bcand, w_slo, w_shi, w_scand;
    logic          w_iempty, w_bempty, w_sempty;
    logic [31:0]   w_bcap;

    always_comb begin
        w_ilo = (r_fino == '0) ? PW'(1) : PW'(r_fino);
        w_ihi = (32'(r_icnt) > INODE_BITS) ? PW'(INODE_BITS) : PW'(r_icnt);
        w_iempty = w_ilo > w_ihi;
        w_is = (r_dir != '0 && r_ipg != '0) ? PW'(r_dir) - PW'(w_rem_rsp.rem) : PW'(1);
        if (w_is < w_ilo || w_is > w_ihi) begin
            w_is = w_ilo;
        end

        w_bcap = 32'(r_fdb) + 32'(BLOCK_BITS) - 32'd1;
        w_bh   = r_bcnt - PW'(1);
        if (32'(w_bh) > w_bcap) begin
            w_bh = PW'(w_bcap);
        end
        if (w_bh > PW'(16'hFFFF)) begin
            w_bh = PW'(16'hFFFF);
        end
        w_blo    = PW'(r_fdb);
        w_bempty = (r_bcnt == '0) || (w_blo > w_bh);
        w_bcand  = (r_sblk == '0) ? w_blo : PW'(r_sblk);
        if (w_bcand < w_blo || w_bcand > w_bh) begin
            w_bcand = w_blo;
        end

        if (r_func == bfss_pkg::FUNC_INODE) begin
            w_slo = w_ilo;  w_shi = w_ihi;  w_sempty = w_iempty;  w_scand = w_is;
        end else begin
            w_slo = w_blo;  w_shi = w_bh;   w_sempty = w_bempty;  w_scand = w_bcand;
        end
    end

    // Probe decode.
    logic          w_over, w_hit, w_used, w_last, w_skip_hit, w_wrap, w_stop;
    logic [PW-1:0] w_next;

    assign w_bitidx = r_isel ? (r_pos - PW'(1)) : (r_pos - PW'(r_fdb));
    assign w_waddr  = w_bitidx[PW-1:5];
    assign w_over   = r_pos > r_hi;
    assign w_hit    = r_cw_v && (r_cw_addr == w_waddr);
    assign w_used   = r_cw_data[w_bitidx[4:0]];
    assign w_last   = (r_pos - r_cand + PW'(1)) == PW'(r_len);
    assign w_skip_hit = r_skip_v && (r_cand <= r_skip);
    assign w_wrap   = r_cand >= r_hi;
    assign w_next   = w_wrap ? r_lo : r_cand + PW'(1);
    assign w_stop   = ((r_k + PW'(1)) == r_n) || (r_use_fin && (w_next == PW'(r_fin)));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfss_pkg::S_IDLE: begin
                if (w_acc) begin
                    priority case (i_req.func)
                        bfss_pkg::FUNC_WRITE: n_state = bfss_pkg::S_IDLE;
                        bfss_pkg::FUNC_INODE: n_state = bfss_pkg::S_DIV;
                        default:              n_state = bfss_pkg::S_SETUP;
                    endcase
                end
            end
            bfss_pkg::S_DIV: begin
                if (w_rem_rsp.done) begin
                    n_state = bfss_pkg::S_SETUP;
                end
            end
            bfss_pkg::S_SETUP: begin
                n_state = w_sempty ? bfss_pkg::S_IDLE : bfss_pkg::S_CAND;
            end
            bfss_pkg::S_CAND: begin
                if (!w_skip_hit) begin
                    n_state = bfss_pkg::S_PROBE;
                end else if (w_stop) begin
                    n_state = bfss_pkg::S_IDLE;
                end
            end
            bfss_pkg::S_PROBE: begin
                if (w_over || (w_hit && w_used)) begin
                    n_state = w_stop ? bfss_pkg::S_IDLE : bfss_pkg::S_CAND;
                end else if (!w_hit) begin
                    n_state = bfss_pkg::S_WAIT;
                end else if (w_last) begin
                    n_state = bfss_pkg::S_IDLE;
                end
            end
            bfss_pkg::S_WAIT: n_state = bfss_pkg::S_PROBE;
            default:          n_state = bfss_pkg::S_IDLE;
        endcase
    end

    // Datapath and result.
    always_comb begin
        n_lo = r_lo;  n_hi = r_hi;  n_n = r_n;  n_k = r_k;
        n_cand = r_cand;  n_pos = r_pos;  n_skip = r_skip;  n_skip_v = r_skip_v;
        n_fin = r_fin;  n_use_fin = r_use_fin;  n_len = r_len;  n_isel = r_isel;
        n_cw_v = r_cw_v;  n_cw_addr = r_cw_addr;  n_cw_data = r_cw_data;
        n_out_v = r_out_v && !o_rsp.ready;
        n_status = r_status;  n_found = r_found;

        unique case (r_state)
            bfss_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_cw_v = 1'b0;
                    if (i_req.func == bfss_pkg::FUNC_WRITE) begin
                        n_out_v  = 1'b1;
                        n_status = bfss_pkg::ST_WRITTEN;
                        n_found  = '0;
                    end
                end
            end
            bfss_pkg::S_SETUP: begin
                n_lo = w_slo;  n_hi = w_shi;  n_cand = w_scand;
                n_n  = w_shi - w_slo + PW'(1);
                n_k  = '0;
                n_skip_v  = 1'b0;
                n_isel    = (r_func == bfss_pkg::FUNC_INODE);
                n_use_fin = (r_func == bfss_pkg::FUNC_RUN);
                n_fin     = (r_fblk == '0) ? r_sblk : r_fblk;
                if (r_func != bfss_pkg::FUNC_RUN) begin
                    n_len = 8'd1;
                end else if (r_rlen == '0) begin
                    n_len = 8'd1;
                end else if (32'(r_rlen) > MAX_RUN) begin
                    n_len = 8'(MAX_RUN);
                end else begin
                    n_len = r_rlen;
                end
                if (w_sempty) begin
                    n_out_v  = 1'b1;
                    n_status = bfss_pkg::ST_NOSPACE;
                    n_found  = '0;
                end
            end
            bfss_pkg::S_CAND: begin
                if (!w_skip_hit) begin
                    n_pos = r_cand;
                end else if (w_stop) begin
                    n_out_v  = 1'b1;
                    n_status = bfss_pkg::ST_NOSPACE;
                    n_found  = '0;
                end else begin
                    n_cand = w_next;
                    n_k    = r_k + PW'(1);
                    if (w_wrap) begin
                        n_skip_v = 1'b0;
                    end
                end
            end
            bfss_pkg::S_PROBE: begin
                if (w_over || (w_hit && w_used)) begin
                    // Every candidate up to the blocking position fails as well.
                    if (w_stop) begin
                        n_out_v  = 1'b1;
                        n_status = bfss_pkg::ST_NOSPACE;
                        n_found  = '0;
                    end else begin
                        n_cand   = w_next;
                        n_k      = r_k + PW'(1);
                        n_skip   = w_over ? r_hi : r_pos;
                        n_skip_v = !w_wrap;
                    end
                end else if (w_hit) begin
                    if (w_last) begin
                        n_out_v  = 1'b1;
                        n_status = bfss_pkg::ST_FOUND;
                        n_found  = r_cand[15:0];
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            bfss_pkg::S_WAIT: begin
                n_cw_v    = 1'b1;
                n_cw_addr = w_waddr;
                n_cw_data = r_isel ? w_ird : w_brd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfss_pkg::S_IDLE;
            r_out_v <= 1'b0;
            r_cw_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            r_cw_v  <= n_cw_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_func <= i_req.func;
            r_dir  <= i_req.dir_inode;
            r_sblk <= i_req.start_block;
            r_fblk <= i_req.finish_block;
            r_rlen <= i_req.run_length;
        end
        r_lo <= n_lo;  r_hi <= n_hi;  r_n <= n_n;  r_k <= n_k;
        r_cand <= n_cand;  r_pos <= n_pos;  r_skip <= n_skip;  r_skip_v <= n_skip_v;
        r_fin <= n_fin;  r_use_fin <= n_use_fin;  r_len <= n_len;  r_isel <= n_isel;
        r_cw_addr <= n_cw_addr;  r_cw_data <= n_cw_data;
        r_status <= n_status;  r_found <= n_found;
    end
endmodule

>>> hdl/bfss_ram.sv
module bfss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/bfss_rem.sv
module bfss_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfss_pkg::t_rem_req i_req,
    output bfss_pkg::t_rem_rsp o_rsp
);
    logic                       r_busy;
    logic                       r_done;
    logic [3:0]                 r_cnt;
    logic [bfss_pkg::INO_W-1:0] r_x;
    logic [bfss_pkg::INO_W-1:0] r_r;
    logic [bfss_pkg::INO_W-1:0] r_d;
    logic [bfss_pkg::INO_W:0]   w_t;
    logic                       w_ge;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
    assign w_t  = {r_r, r_x[bfss_pkg::INO_W-1]};
    assign w_ge = w_t >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(bfss_pkg::INO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_req.dividend;
            r_d <= i_req.divisor;
            r_r <= '0;
        end else if (r_busy) begin
            r_x <= r_x << 1;
            r_r <= w_ge ? bfss_pkg::INO_W'(w_t - {1'b0, r_d}) : w_t[bfss_pkg::INO_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_r;
endmodule

>>> verif/tb_bitmap_free_slot_search.sv
`timescale 1ns / 100ps

module tb_bitmap_free_slot_search;

    localparam int BLOCK_BITS  = 65536;
    localparam int INODE_BITS  = 16384;
    localparam int MAX_RUN     = 255;
    localparam int BLOCK_WORDS = BLOCK_BITS / 32;
    localparam int INODE_WORDS = INODE_BITS / 32;
    localparam int CYCLE_LIMIT = 4000000;
    // Words 0 to 31 of both bitmaps are loaded first; words 16 to 31 stay clear so
    // that wide block searches reach clear bits before leaving the loaded window.
    localparam int LOAD_WORDS  = 32;

    typedef struct {
        logic [1:0]                  func;
        logic                        sel;
        logic [10:0]                 widx;
        logic [bfss_pkg::WORD_W-1:0] wdata;
        logic [bfss_pkg::INO_W-1:0]  dir;
        logic [bfss_pkg::BLK_W-1:0]  sblk;
        logic [bfss_pkg::BLK_W-1:0]  fblk;
        logic [bfss_pkg::LEN_W-1:0]  len;
    } t_alloc_req;

    typedef struct {
        logic [1:0]                 status;
        logic [bfss_pkg::BLK_W-1:0] number;
    } t_alloc_rsp;

    // Mirror of both bitmaps and the geometry registers, with a queue of the
    // answers still owed by the block.
    class slot_scoreboard;
        logic [31:0] blk_map [BLOCK_WORDS];
        logic [31:0] ino_map [INODE_WORDS];
        int unsigned ipg, icnt, fino, bcnt, fdb;
        t_alloc_rsp  owed [$];
        int          mismatches;
        int          answers;
        int          found_cnt;
        int          nospace_cnt;

        function void restore_defaults();
            ipg  = 2048;
            icnt = 16384;
            fino = 11;
            bcnt = 65536;
            fdb  = 1;
        endfunction

        function void set_reg(logic [bfss_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
            case (idx)
                bfss_pkg::CFG_IPG:  ipg  = val & 32'h7fff;
                bfss_pkg::CFG_ICNT: icnt = val & 32'h7fff;
                bfss_pkg::CFG_FINO: fino = val & 32'h7fff;
                bfss_pkg::CFG_BCNT: bcnt = val & 32'h1ffff;
                bfss_pkg::CFG_FDB:  fdb  = val & 32'h1;
                default: ;
            endcase
        endfunction

        function bit inode_used(int unsigned n);
            if ((n >> 5) >= INODE_WORDS) return 1'b1;
            return ino_map[n >> 5][n & 31];
        endfunction

        function bit block_used(int unsigned b);
            int unsigned n;
            n = b - fdb;
            if ((n >> 5) >= BLOCK_WORDS) return 1'b1;
            return blk_map[n >> 5][n & 31];
        endfunction

        function bit block_span(output int unsigned lo, output int unsigned hi);
            if (bcnt == 0) return 1'b0;
            hi = bcnt - 1;
            if (hi > fdb + BLOCK_BITS - 1) hi = fdb + BLOCK_BITS - 1;
            if (hi > 16'hffff) hi = 16'hffff;
            lo = fdb;
            return lo <= hi;
        endfunction

        function bit alloc_inode(int unsigned dir, output int unsigned hit);
            int unsigned lo, hi, grp, s, i;
            lo  = (fino != 0) ? fino : 1;
            hi  = icnt;
            grp = 0;
            if (hi > INODE_BITS) hi = INODE_BITS;
            if (hi > 16'hffff) hi = 16'hffff;
            if (lo > hi) return 1'b0;
            if (dir > 0 && ipg != 0) grp = (dir - 1) / ipg;
            s = grp * ipg + 1;
            if (s < lo) s = lo;
            if (s > hi) s = lo;
            i = s;
            for (int unsigned k = 0; k < hi - lo + 1; k++) begin
                if (!inode_used(i - 1)) begin
                    hit = i;
                    return 1'b1;
                end
                i = (i >= hi) ? lo : i + 1;
            end
            return 1'b0;
        endfunction

        function bit alloc_block(int unsigned goal, output int unsigned hit);
            int unsigned lo, hi, i;
            if (!block_span(lo, hi)) return 1'b0;
            i = (goal != 0) ? goal : lo;
            if (i < lo || i > hi) i = lo;
            for (int unsigned k = 0; k < hi - lo + 1; k++) begin
                if (!block_used(i)) begin
                    hit = i;
                    return 1'b1;
                end
                i = (i >= hi) ? lo : i + 1;
            end
            return 1'b0;
        endfunction

        function bit run_clear(int unsigned b, int unsigned len, int unsigned hi);
            for (int unsigned j = 0; j < len; j++) begin
                if (b + j > hi || block_used(b + j)) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit alloc_run(int unsigned start, int unsigned fin, int unsigned len,
                               output int unsigned hit);
            int unsigned lo, hi, b;
            if (!block_span(lo, hi)) return 1'b0;
            if (len == 0) len = 1;
            if (len > MAX_RUN) len = MAX_RUN;
            if (fin == 0) fin = start;
            b = (start != 0) ? start : lo;
            if (b < lo || b > hi) b = lo;
            for (int unsigned k = 0; k < hi - lo + 1; k++) begin
                if (run_clear(b, len, hi)) begin
                    hit = b;
                    return 1'b1;
                end
                b = (b >= hi) ? lo : b + 1;
                if (b == fin) break;
            end
            return 1'b0;
        endfunction

        function void note_request(t_alloc_req r);
            t_alloc_rsp  e;
            int unsigned hit;
            bit          ok;
            hit = 0;
            ok  = 1'b0;
            case (r.func)
                bfss_pkg::FUNC_WRITE: begin
                    if (r.sel == 1'b0) blk_map[r.widx] = r.wdata;
                    else if (r.widx < INODE_WORDS) ino_map[r.widx] = r.wdata;
                end
                bfss_pkg::FUNC_INODE: ok = alloc_inode(r.dir, hit);
                bfss_pkg::FUNC_BLOCK: ok = alloc_block(r.sblk, hit);
                default:              ok = alloc_run(r.sblk, r.fblk, r.len, hit);
            endcase
            if (r.func == bfss_pkg::FUNC_WRITE) begin
                e.status = bfss_pkg::ST_WRITTEN;
                e.number = '0;
            end else if (ok) begin
                e.status = bfss_pkg::ST_FOUND;
                e.number = hit[bfss_pkg::BLK_W-1:0];
                found_cnt++;
            end else begin
                e.status = bfss_pkg::ST_NOSPACE;
                e.number = '0;
                nospace_cnt++;
            end
            owed.push_back(e);
        endfunction

        function void check_result(logic [1:0] status, logic [bfss_pkg::BLK_W-1:0] number);
            t_alloc_rsp e;
            answers++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d number=%0d",
                             status, number);
                return;
            end
            e = owed.pop_front();
            if (status !== e.status || number !== e.number) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected status=%0d number=%0d, %s%0d %s%0d",
                             answers, e.status, e.number, "got status=", status,
                             "number=", number);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bfss_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bfss_pkg::CFG_DATA_W-1:0] i_cfg_data;

    bfss_req_if req_ch ();
    bfss_rsp_if rsp_ch ();

    bitmap_free_slot_search #(
        .BLOCK_BITS(BLOCK_BITS),
        .INODE_BITS(INODE_BITS),
        .MAX_RUN   (MAX_RUN)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    slot_scoreboard sb;
    int src_idle;
    int snk_idle;
    int cycles = 0;
    int searches;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The response side stalls at random; a word is taken when valid and ready meet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.found_number);
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic push_request(t_alloc_req r);
        while ($urandom_range(99) < src_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= r.func;
        req_ch.bitmap_select <= r.sel;
        req_ch.word_index    <= r.widx;
        req_ch.word_data     <= r.wdata;
        req_ch.dir_inode     <= r.dir;
        req_ch.start_block   <= r.sblk;
        req_ch.finish_block  <= r.fblk;
        req_ch.run_length    <= r.len;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(r);
        if (r.func != bfss_pkg::FUNC_WRITE) searches++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [bfss_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[bfss_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_geometry(int unsigned ipg, int unsigned icnt, int unsigned fino,
                                int unsigned bcnt, int unsigned fdb);
        drain();
        cfg_write(bfss_pkg::CFG_IPG, ipg);
        cfg_write(bfss_pkg::CFG_ICNT, icnt);
        cfg_write(bfss_pkg::CFG_FINO, fino);
        cfg_write(bfss_pkg::CFG_BCNT, bcnt);
        cfg_write(bfss_pkg::CFG_FDB, fdb);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_alloc_req make_req(logic [1:0] func, logic sel, int unsigned widx,
                                            logic [31:0] wdata, int unsigned dir,
                                            int unsigned sblk, int unsigned fblk,
                                            int unsigned len);
        t_alloc_req r;
        r.func  = func;
        r.sel   = sel;
        r.widx  = widx[10:0];
        r.wdata = wdata;
        r.dir   = dir[bfss_pkg::INO_W-1:0];
        r.sblk  = sblk[bfss_pkg::BLK_W-1:0];
        r.fblk  = fblk[bfss_pkg::BLK_W-1:0];
        r.len   = len[bfss_pkg::LEN_W-1:0];
        return r;
    endfunction

    // Writes stay inside the words that the current geometry searches, so the
    // searches keep meeting freshly changed, mostly full words. A stray write goes
    // above the loaded window, which the small layouts never search.
    function automatic t_alloc_req random_req(bit wide);
        t_alloc_req  r;
        int unsigned p, bspan, ispan;
        r = make_req(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom_range(2047),
                     $urandom, $urandom_range(32767), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(255));
        bspan = wide ? 700 : sb.bcnt + 2;
        ispan = wide ? 700 : sb.icnt + 2;
        p = $urandom_range(99);
        if (p < 30) begin
            r.func = bfss_pkg::FUNC_WRITE;
            if ($urandom_range(9) != 0)
                r.widx = 11'(wide ? $urandom_range(15)
                                  : (r.sel ? $urandom_range(ispan >> 5)
                                           : $urandom_range(bspan >> 5)));
            else
                r.widx = 11'($urandom_range(2047, LOAD_WORDS));
            p = $urandom_range(9);
            if (p == 0)      r.wdata = '1;
            else if (p == 1) r.wdata = '0;
            else if (p < 8)  r.wdata = $urandom | $urandom;
        end else begin
            if (r.func == bfss_pkg::FUNC_WRITE) r.func = bfss_pkg::FUNC_RUN;
            if ($urandom_range(1)) r.dir = 15'($urandom_range(ispan));
            p = $urandom_range(9);
            if (p < 2)               r.sblk = '0;
            else if (p < 7 || wide)  r.sblk = 16'($urandom_range(bspan));
            p = $urandom_range(9);
            if (p < 3)      r.fblk = '0;
            else if (p < 7) r.fblk = 16'($urandom_range(bspan));
            p = $urandom_range(9);
            if (p < 6)      r.len = 8'($urandom_range(8));
            else if (p < 9) r.len = 8'($urandom_range(40));
        end
        return r;
    endfunction

    initial begin
        t_alloc_req dir_list [$];
        sb = new();
        sb.restore_defaults();
        sb.mismatches  = 0;
        sb.answers     = 0;
        sb.found_cnt   = 0;
        sb.nospace_cnt = 0;
        searches = 0;
        src_idle = 17;
        snk_idle = 61;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= bfss_pkg::FUNC_WRITE;
        req_ch.bitmap_select <= 1'b0;
        req_ch.word_index    <= '0;
        req_ch.word_data     <= '0;
        req_ch.dir_inode     <= '0;
        req_ch.start_block   <= '0;
        req_ch.finish_block  <= '0;
        req_ch.run_length    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The low words are loaded clear; every search below stays inside them or
        // inside the few high words written explicitly.
        for (int w = 0; w < LOAD_WORDS; w++)
            push_request(make_req(bfss_pkg::FUNC_WRITE, 1'b0, w, 32'h0, 0, 0, 0, 0));
        for (int w = 0; w < LOAD_WORDS; w++)
            push_request(make_req(bfss_pkg::FUNC_WRITE, 1'b1, w, 32'h0, 0, 0, 0, 0));

        dir_list.push_back(make_req(bfss_pkg::FUNC_WRITE, 1'b1, 0, 32'hffff_ffff, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_WRITE, 1'b1, 448, 32'h0000_0001, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_INODE, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_INODE, 1'b0, 0, 0, 16384, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_INODE, 1'b0, 0, 0, 32767, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_WRITE, 1'b1, 2047, 32'h1234_5678, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_WRITE, 1'b1, 511, 32'hffff_ffff, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_INODE, 1'b0, 0, 0, 16383, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_WRITE, 1'b0, 2047, 32'hffff_ffff, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_WRITE, 1'b0, 0, 32'hffff_fffe, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_BLOCK, 1'b0, 0, 0, 0, 65535, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_BLOCK, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_BLOCK, 1'b0, 0, 0, 0, 2, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_RUN, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_list.push_back(make_req(bfss_pkg::FUNC_RUN, 1'b0, 0, 0, 0, 0, 0, 255));
        dir_list.push_back(make_req(bfss_pkg::FUNC_RUN, 1'b0, 0, 0, 0, 2, 5, 1));
        dir_list.push_back(make_req(bfss_pkg::FUNC_RUN, 1'b0, 0, 0, 0, 65535, 0, 1));
        dir_list.push_back(make_req(bfss_pkg::FUNC_RUN, 1'b0, 0, 0, 0, 65535, 65535, 255));
        dir_list.push_back(make_req(bfss_pkg::FUNC_RUN, 1'b0, 0, 0, 0, 65534, 0, 2));
        dir_list.push_back(make_req(bfss_pkg::FUNC_RUN, 1'b0, 0, 0, 0, 40, 33, 8));
        foreach (dir_list[i]) push_request(dir_list[i]);

        // Geometry sweep: the register extremes in phases 0, 1 and 3, random small layouts in the others.
        for (int ph = 0; ph < 6; ph++) begin
            bit wide;
            wide = (ph == 0 || ph == 3);
            case (ph)
                0: set_geometry(0, 32767, 0, 131071, 0);
                1: set_geometry(1, 1, 1, 0, 0);
                3: set_geometry(32767, 16384, 16384, 65536, 1);
                default: set_geometry($urandom_range(64), $urandom_range(400),
                                      $urandom_range(60), $urandom_range(300),
                                      $urandom_range(1));
            endcase
            if (ph == 2) begin
                src_idle = 61;
                snk_idle = 17;
            end else if (ph == 4) begin
                src_idle = 0;
                snk_idle = 0;
            end
            repeat (35) push_request(random_req(wide));
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d searches (%0d found, %0d without space) over the reset layout",
                 searches, sb.found_cnt, sb.nospace_cnt);
        $display("and six more, with %0d results checked and %0d mismatches.",
                 sb.answers, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/bfss_pkg.sv
hdl/bfss_req_if.sv
hdl/bfss_rsp_if.sv
hdl/bfss_ram.sv
hdl/bfss_rem.sv
hdl/bitmap_free_slot_search.sv
verif/tb_bitmap_free_slot_search.sv
